>>> sv/circular_queue_with_search_defines.svh
// ----------------------------------------------------------------------------
// circular queue with search: assertion macros
// shared property forms for the checker, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define CQS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cqs_pkg.sv
// ----------------------------------------------------------------------------
// cqs_pkg
// shared codes, types and defaults of the circular queue with search
// ----------------------------------------------------------------------------
package cqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_CLR    = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SEARCH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

>>> sv/cqs_ram.sv
// ----------------------------------------------------------------------------
// cqs_ram
// slot storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cqs_ram #(
    parameter int DEPTH      = cqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cqs_pkg::DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  cqs_pkg::ram_ctl_t        ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);
    import cqs_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/circular_queue_with_search.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search
// ring-buffer fifo of DEPTH words with enqueue, dequeue, clear and search
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries cmd and data_value; a word is
//   taken when in_valid is high and in_stall low. one command is in flight
//   at a time: in_stall stays high from acceptance until its result word has
//   been loaded into the output register.
//   output channel (out_valid / out_stall) carries status, found, position,
//   front_value, rear_value and count; the output register holds its word
//   while out_stall is high, and the next command may already be accepted.
//   steps, from acceptance to the load of the output register:
//     enqueue, clear, refused commands, dequeue that empties the queue: straight to S_OUT
//     any other dequeue: S_DEQ (one read of the new front slot), then S_OUT
//     search: S_SEARCH walks from the front until a hit or the rear slot; the
//       single read port of the slot memory compares one slot per cycle
//   the next word is taken once the load has returned the fsm to S_IDLE;
//   a stalled output delays the load and so the next acceptance.
//   reset: queue empty, head at slot 0, tail at DEPTH-1, no result pending;
//   slot contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
module circular_queue_with_search #(
    parameter int DEPTH      = cqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cqs_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 cmd,
    input  logic [DATA_WIDTH-1:0]      data_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic                       found,
    output logic [$clog2(DEPTH)-1:0]   position,
    output logic [DATA_WIDTH-1:0]      front_value,
    output logic [DATA_WIDTH-1:0]      rear_value,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import cqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // ring increment that also works for non power of two depths
    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        if (idx == AW'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // fsm
    state_t state_reg, state_next;

    // queue pointers and shadow copies of the end slots
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] rear_reg, rear_next;

    // search walk
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         left_reg, left_next;

    // pending result fields
    logic [1:0]    res_status_reg, res_status_next;
    logic          res_found_reg, res_found_next;
    logic [AW-1:0] res_pos_reg, res_pos_next;

    // output register
    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic                  out_found_reg;
    logic [AW-1:0]         out_pos_reg;
    logic [DATA_WIDTH-1:0] out_front_reg;
    logic [DATA_WIDTH-1:0] out_rear_reg;
    logic [CW-1:0]         out_count_reg;

    // memory port
    ram_ctl_t              ram_ctl;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic          accept;
    logic          load_ok;
    logic          out_load;
    logic          hit;
    logic          queue_empty;
    logic          queue_full;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    cmd_t          cmd_in;

    assign cmd_in      = cmd_t'(cmd);
    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign load_ok     = !out_valid_reg || !out_stall;
    assign out_load    = (state_reg == S_OUT) && load_ok;
    assign queue_empty = (cnt_reg == '0);
    assign queue_full  = (cnt_reg == CW'(DEPTH));
    assign head_inc    = ring_next(head_reg);
    assign tail_inc    = ring_next(tail_reg);
    // read data in the search state is the slot at ptr_reg
    assign hit         = (ram_rdata == key_reg);

    cqs_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .waddr (tail_inc),
        .wdata (data_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_in)
                        CMD_DEQ:    state_next = (cnt_reg > CW'(1)) ? S_DEQ : S_OUT;
                        CMD_SEARCH: state_next = queue_empty ? S_OUT : S_SEARCH;
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_DEQ:
            begin
                state_next = S_OUT;
            end
            S_SEARCH:
            begin
                if (hit || (left_reg == '0))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        key_next        = key_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        ram_ctl         = '0;
        ram_raddr       = head_inc;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STATUS_OK;
                    res_found_next  = 1'b0;
                    res_pos_next    = '0;
                    case (cmd_in)
                        CMD_ENQ:
                        begin
                            if (queue_full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_ctl.wr_en = 1'b1;
                                tail_next     = tail_inc;
                                cnt_next      = cnt_reg + 1'b1;
                                rear_next     = data_value;
                                if (queue_empty)
                                begin
                                    front_next = data_value;
                                end
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (queue_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // fetch the new front slot
                                ram_ctl.rd_en = 1'b1;
                                ram_raddr     = head_inc;
                                head_next     = head_inc;
                                cnt_next      = cnt_reg - 1'b1;
                            end
                        end
                        CMD_CLR:
                        begin
                            // head moves to the slot after the tail
                            head_next = tail_inc;
                            cnt_next  = '0;
                        end
                        CMD_SEARCH:
                        begin
                            if (queue_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                ram_ctl.rd_en = 1'b1;
                                ram_raddr     = head_reg;
                                ptr_next      = head_reg;
                                left_next     = AW'(cnt_reg - 1'b1);
                                key_next      = data_value;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                front_next = ram_rdata;
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = ptr_reg;
                end
                else if (left_reg != '0)
                begin
                    ram_ctl.rd_en = 1'b1;
                    ram_raddr     = ring_next(ptr_reg);
                    ptr_next      = ring_next(ptr_reg);
                    left_next     = left_reg - 1'b1;
                end
            end
            default:
            begin
                ram_ctl = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= AW'(DEPTH - 1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        rear_reg       <= rear_next;
        key_reg        <= key_next;
        ptr_reg        <= ptr_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_pos_reg    <= res_pos_reg;
            out_count_reg  <= cnt_reg;
            // an empty queue reports zero end values
            out_front_reg  <= queue_empty ? '0 : front_reg;
            out_rear_reg   <= queue_empty ? '0 : rear_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign position    = out_pos_reg;
    assign front_value = out_front_reg;
    assign rear_value  = out_rear_reg;
    assign count       = out_count_reg;

endmodule

>>> sv/cqs_checker.sv
// ----------------------------------------------------------------------------
// cqs_checker
// port-level checks of the circular queue with search, bound to the top
// ----------------------------------------------------------------------------
`include "circular_queue_with_search_defines.svh"

module cqs_checker #(
    parameter int DEPTH      = cqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cqs_pkg::DATA_WIDTH_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [1:0]                 cmd,
    input logic [DATA_WIDTH-1:0]      data_value,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [1:0]                 status,
    input logic                       found,
    input logic [$clog2(DEPTH)-1:0]   position,
    input logic [DATA_WIDTH-1:0]      front_value,
    input logic [DATA_WIDTH-1:0]      rear_value,
    input logic [$clog2(DEPTH+1)-1:0] count
);
    import cqs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // a stalled result word holds
    `CQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(count) && $stable(front_value) && $stable(rear_value) && $stable(found) && $stable(position), "result word changed while stalled")

    `CQS_ASSERT_SAME(a_count_range, out_valid, count <= CW'(DEPTH), "count above depth")

    `CQS_ASSERT_SAME(a_empty_zero, out_valid && (count == '0), (front_value == '0) && (rear_value == '0), "empty queue reports nonzero end value")

    `CQS_ASSERT_SAME(a_full_refuse, out_valid && (status == STATUS_FULL), count == CW'(DEPTH), "full refusal with queue not full")

    `CQS_ASSERT_SAME(a_found_ok, out_valid && (found || (position != '0)), status == STATUS_OK, "search hit reported with error status")

endmodule

bind circular_queue_with_search cqs_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_cqs_checker (.*);
